// ===== src/dnsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsr_pkg
// Shared types, constants and helpers for the catch-all DNS responder.
// ----------------------------------------------------------------------------
package dnsr_pkg;

  localparam int WORD_BYTES   = 8;
  localparam int LB           = $clog2(WORD_BYTES);
  localparam int HEADER_BYTES = 12;
  localparam int ANSWER_BYTES = 16;
  // Zero byte that ends the name, then type and class.
  localparam int QTAIL_BYTES  = 5;

  localparam logic [31:0] ADDR_RESET = 32'hC0A8_0401;
  localparam logic [31:0] TTL_RESET  = 32'h0000_003C;

  localparam logic [15:0] QR_FLAG     = 16'h8000;
  localparam logic [15:0] REPLY_FLAGS = 16'h8180;
  localparam logic [15:0] NAME_PTR    = {8'hC0, 8'h0C};
  localparam logic [15:0] RR_TYPE_A   = 16'h0001;
  localparam logic [15:0] RR_CLASS_IN = 16'h0001;
  localparam logic [15:0] RR_RDLEN_A  = 16'h0004;

  // Header byte positions.
  localparam logic [3:0] HDR_FLAGS_HI = 4'd2;
  localparam logic [3:0] HDR_FLAGS_LO = 4'd3;
  localparam logic [3:0] HDR_QD_HI    = 4'd4;
  localparam logic [3:0] HDR_QD_LO    = 4'd5;
  localparam logic [3:0] HDR_AN_HI    = 4'd6;
  localparam logic [3:0] HDR_AN_LO    = 4'd7;
  localparam logic [3:0] HDR_NS_HI    = 4'd8;
  localparam logic [3:0] HDR_NS_LO    = 4'd9;
  localparam logic [3:0] HDR_AR_HI    = 4'd10;
  localparam logic [3:0] HDR_AR_LO    = 4'd11;

  // Configuration register indexes (byte address bit 2).
  localparam logic CFG_IDX_ADDR = 1'b0;
  localparam logic CFG_IDX_TTL  = 1'b1;

  typedef struct packed {
    logic load;
    logic hdr_rd;
    logic name_rd;
    logic name_step;
    logic p_init;
    logic qend_set;
    logic emit_rd;
    logic emit_wr;
    logic drop_wr;
  } dnsr_cmd_t;

  typedef struct packed {
    logic short_pkt;
    logic hdr_bad;
    logic name_end;
    logic label_zero;
    logic jump_out;
    logic q_bad;
    logic slot_free;
    logic emit_last;
  } dnsr_sts_t;

  // Byte of the appended A record at the given offset.
  function automatic logic [7:0] answer_byte(input logic [3:0]  off,
                                             input logic [31:0] ttl,
                                             input logic [31:0] addr);
    logic [7:0] b;
    case (off)
      4'd0:    b = NAME_PTR[15:8];
      4'd1:    b = NAME_PTR[7:0];
      4'd2:    b = RR_TYPE_A[15:8];
      4'd3:    b = RR_TYPE_A[7:0];
      4'd4:    b = RR_CLASS_IN[15:8];
      4'd5:    b = RR_CLASS_IN[7:0];
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd10:   b = RR_RDLEN_A[15:8];
      4'd11:   b = RR_RDLEN_A[7:0];
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      4'd15:   b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/dnsr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dnsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/dnsr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsr_ctrl
// Sequencer: load beats, check header, walk labels, emit reply or drop.
// ----------------------------------------------------------------------------
module dnsr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  dnsr_pkg::dnsr_sts_t sts,
  output dnsr_pkg::dnsr_cmd_t cmd
);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_HDR_RD   = 4'd1;
  localparam logic [3:0] S_HDR_CHK  = 4'd2;
  localparam logic [3:0] S_NAME_RD  = 4'd3;
  localparam logic [3:0] S_NAME_CHK = 4'd4;
  localparam logic [3:0] S_QEND     = 4'd5;
  localparam logic [3:0] S_EMIT_RD  = 4'd6;
  localparam logic [3:0] S_EMIT_WR  = 4'd7;
  localparam logic [3:0] S_DROP     = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_LOAD);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_next = S_HDR_RD;
          end
        end
      end
      S_HDR_RD: begin
        if (sts.short_pkt) begin
          state_next = S_DROP;
        end else begin
          cmd.hdr_rd = 1'b1;
          state_next = S_HDR_CHK;
        end
      end
      S_HDR_CHK: begin
        if (sts.hdr_bad) begin
          state_next = S_DROP;
        end else begin
          cmd.p_init = 1'b1;
          state_next = S_NAME_RD;
        end
      end
      S_NAME_RD: begin
        if (sts.name_end) begin
          state_next = S_QEND;
        end else begin
          cmd.name_rd = 1'b1;
          state_next  = S_NAME_CHK;
        end
      end
      S_NAME_CHK: begin
        if (sts.label_zero) begin
          state_next = S_QEND;
        end else if (sts.jump_out) begin
          state_next = S_DROP;
        end else begin
          cmd.name_step = 1'b1;
          state_next    = S_NAME_RD;
        end
      end
      S_QEND: begin
        if (sts.q_bad) begin
          state_next = S_DROP;
        end else begin
          cmd.qend_set = 1'b1;
          state_next   = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (sts.slot_free) begin
          cmd.emit_wr = 1'b1;
          state_next  = sts.emit_last ? S_LOAD : S_EMIT_RD;
        end
      end
      S_DROP: begin
        if (sts.slot_free) begin
          cmd.drop_wr = 1'b1;
          state_next  = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/dnsr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsr_dp
// Datapath: byte-lane packet store, length and name pointers, reply builder
// and output register.
// ----------------------------------------------------------------------------
module dnsr_dp #(
  parameter int BUFFER_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         in_data,
  input  logic [3:0]          in_count,
  input  logic                in_last,
  input  logic [31:0]         cfg_addr,
  input  logic [31:0]         cfg_ttl,
  input  logic                out_ready,
  input  dnsr_pkg::dnsr_cmd_t cmd,
  output dnsr_pkg::dnsr_sts_t sts,
  output logic                out_valid,
  output logic [63:0]         out_data,
  output logic [3:0]          out_count,
  output logic                out_last,
  output logic                dropped
);

  localparam int WB   = dnsr_pkg::WORD_BYTES;
  localparam int LB   = dnsr_pkg::LB;
  localparam int ROWS = (BUFFER_BYTES + dnsr_pkg::WORD_BYTES - 1) / dnsr_pkg::WORD_BYTES;
  localparam int RW   = $clog2(ROWS);
  localparam int LW   = $clog2(BUFFER_BYTES + 1);
  // Room for a label jump of up to 256 past the end of the store.
  localparam int PW   = $clog2(BUFFER_BYTES + 512);
  localparam logic [PW-1:0] BUF_P = PW'(BUFFER_BYTES);
  localparam logic [PW-1:0] ANS_P = PW'(dnsr_pkg::ANSWER_BYTES);
  localparam logic [PW-1:0] WB_P  = PW'(dnsr_pkg::WORD_BYTES);

  logic [LW-1:0] byte_total;
  logic [LW-1:0] len;
  logic [PW-1:0] p;
  logic [PW-1:0] qend;
  logic [RW-1:0] k;

  logic [3:0]    cnt;
  logic [PW-1:0] base;
  logic [PW-1:0] tot_sum;
  logic [PW-1:0] tot_new;

  logic [WB-1:0] we;
  logic [RW-1:0] wrow [WB];
  logic [7:0]    wdat [WB];
  logic [7:0]    rdat [WB];
  logic [7:0]    obyte [WB];
  logic          re;
  logic [RW-1:0] rd_row;

  logic [PW-1:0] p_len;
  logic [7:0]    name_byte;
  logic [PW-1:0] p_jump;
  logic [PW-1:0] q_end;
  logic [PW-1:0] rlen;
  logic [PW-1:0] wbase;
  logic [PW-1:0] rem;
  logic [63:0]   emit_word;
  logic [3:0]    emit_count;

  // Counts above a full word count as a full word.
  assign cnt     = (in_count > 4'(WB)) ? 4'(WB) : in_count;
  assign base    = PW'(byte_total);
  assign tot_sum = base + PW'(cnt);
  assign tot_new = (tot_sum > BUF_P) ? BUF_P : tot_sum;

  assign re     = cmd.hdr_rd | cmd.name_rd | cmd.emit_rd;
  assign rd_row = cmd.hdr_rd  ? '0 :
                  cmd.name_rd ? p[RW+LB-1:LB] : k;

  assign wbase = PW'({k, LB'(0)});
  assign rlen  = qend + ANS_P;
  assign rem   = rlen - wbase;
  assign emit_count = (rem > WB_P) ? 4'(WB) : rem[3:0];

  genvar L;
  generate
    for (L = 0; L < WB; L++) begin : gen_lane
      logic [LB-1:0] li;
      logic [PW-1:0] la;
      logic [PW-1:0] oa;
      logic [PW-1:0] off;

      // Each lane holds every eighth byte; a beat lands at most once per lane.
      assign li      = LB'(L) - byte_total[LB-1:0];
      assign la      = base + PW'(li);
      assign we[L]   = cmd.load && (4'(li) < cnt) && (la < BUF_P);
      assign wrow[L] = la[RW+LB-1:LB];
      assign wdat[L] = in_data[6'({~li, 3'b000}) +: 8];

      dnsr_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
      ) u_lane (
        .clk   (clk),
        .we    (we[L]),
        .waddr (wrow[L]),
        .wdata (wdat[L]),
        .re    (re),
        .raddr (rd_row),
        .rdata (rdat[L])
      );

      assign oa  = wbase + PW'(L);
      assign off = oa - qend;

      always_comb begin
        if (oa >= rlen) begin
          obyte[L] = 8'h00;
        end else if (oa >= qend) begin
          obyte[L] = dnsr_pkg::answer_byte(off[3:0], cfg_ttl, cfg_addr);
        end else if (oa < PW'(dnsr_pkg::HEADER_BYTES)) begin
          case (oa[3:0])
            dnsr_pkg::HDR_FLAGS_HI: obyte[L] = dnsr_pkg::REPLY_FLAGS[15:8];
            dnsr_pkg::HDR_FLAGS_LO: obyte[L] = dnsr_pkg::REPLY_FLAGS[7:0];
            dnsr_pkg::HDR_AN_HI:    obyte[L] = 8'h00;
            dnsr_pkg::HDR_AN_LO:    obyte[L] = 8'h01;
            dnsr_pkg::HDR_NS_HI:    obyte[L] = 8'h00;
            dnsr_pkg::HDR_NS_LO:    obyte[L] = 8'h00;
            dnsr_pkg::HDR_AR_HI:    obyte[L] = 8'h00;
            dnsr_pkg::HDR_AR_LO:    obyte[L] = 8'h00;
            default:                obyte[L] = rdat[L];
          endcase
        end else begin
          obyte[L] = rdat[L];
        end
      end

      assign emit_word[(WB-1-L)*8 +: 8] = obyte[L];
    end
  endgenerate

  assign p_len     = PW'(len);
  assign name_byte = rdat[p[LB-1:0]];
  assign p_jump    = p + PW'(name_byte) + PW'(1);
  assign q_end     = p + PW'(dnsr_pkg::QTAIL_BYTES);

  always_comb begin
    sts            = '0;
    sts.short_pkt  = (len < LW'(dnsr_pkg::HEADER_BYTES));
    sts.hdr_bad    = ((rdat[dnsr_pkg::HDR_FLAGS_HI[LB-1:0]] &
                       dnsr_pkg::QR_FLAG[15:8]) != 8'h00) ||
                     ((rdat[dnsr_pkg::HDR_QD_HI[LB-1:0]] == 8'h00) &&
                      (rdat[dnsr_pkg::HDR_QD_LO[LB-1:0]] == 8'h00));
    sts.name_end   = (p >= p_len);
    sts.label_zero = (name_byte == 8'h00);
    sts.jump_out   = (p_jump >= p_len);
    sts.q_bad      = (q_end > p_len) || ((q_end + ANS_P) > BUF_P);
    sts.slot_free  = !out_valid || out_ready;
    sts.emit_last  = ((wbase + WB_P) >= rlen);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total <= '0;
    end else if (cmd.load) begin
      byte_total <= in_last ? '0 : LW'(tot_new);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_last) begin
      len <= LW'(tot_new);
    end
    if (cmd.p_init) begin
      p <= PW'(dnsr_pkg::HEADER_BYTES);
    end else if (cmd.name_step) begin
      p <= p_jump;
    end
    if (cmd.qend_set) begin
      qend <= q_end;
    end
    if (cmd.qend_set) begin
      k <= '0;
    end else if (cmd.emit_wr) begin
      k <= k + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_wr || cmd.drop_wr) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_wr) begin
      out_data  <= emit_word;
      out_count <= emit_count;
      out_last  <= sts.emit_last;
      dropped   <= 1'b0;
    end else if (cmd.drop_wr) begin
      out_data  <= '0;
      out_count <= '0;
      out_last  <= 1'b1;
      dropped   <= 1'b1;
    end
  end

endmodule

// ===== src/catch_all_dns_responder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catch_all_dns_responder
// Answers every well-formed DNS query with one A record for the configured address.
// ----------------------------------------------------------------------------
// A query enters on the in_* channel as 8-byte beats, earliest byte on top,
// in_count giving the valid bytes and in_last marking the final beat. Beats
// are stored one per cycle while in_ready is high. After the last beat the
// block checks the header (a store read, then a check) and walks the
// question name, a store read and a check per label. It then sends the reply
// on the out_* channel, a row read and an output load per beat, or a single
// beat with dropped set. The next query is taken once the final reply beat is
// in the output register, even while that beat still waits for out_ready.
// A stalled receiver holds the output register and pauses the reply.
// Bytes beyond BUFFER_BYTES are discarded. The APB port holds the answer
// address (0x0) and TTL (0x4). Reset clears the byte count and the output
// valid flag and restores the register defaults; the packet store is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module catch_all_dns_responder #(
  parameter int BUFFER_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data,
  input  logic [3:0]  in_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data,
  output logic [3:0]  out_count,
  output logic        out_last,
  output logic        dropped
);

  logic [31:0] answer_address;
  logic [31:0] answer_ttl;
  logic        cfg_wr;

  dnsr_pkg::dnsr_cmd_t cmd;
  dnsr_pkg::dnsr_sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= dnsr_pkg::ADDR_RESET;
      answer_ttl     <= dnsr_pkg::TTL_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        dnsr_pkg::CFG_IDX_ADDR: answer_address <= pwdata;
        dnsr_pkg::CFG_IDX_TTL:  answer_ttl     <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dnsr_pkg::CFG_IDX_ADDR: prdata = answer_address;
      dnsr_pkg::CFG_IDX_TTL:  prdata = answer_ttl;
      default:                prdata = '0;
    endcase
  end

  dnsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dnsr_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .in_count  (in_count),
    .in_last   (in_last),
    .cfg_addr  (answer_address),
    .cfg_ttl   (answer_ttl),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_count (out_count),
    .out_last  (out_last),
    .dropped   (dropped)
  );

endmodule

// ===== src/dnsr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsr_checker
// Port-level checks of the responder's output beats.
// ----------------------------------------------------------------------------
module dnsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_data,
  input logic [3:0]  out_count,
  input logic        out_last,
  input logic        dropped
);

  // A stalled beat holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_count))
    else $error("output beat changed while stalled");

  // A drop is a single empty final beat.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> out_last && out_count == 4'd0 && out_data == 64'd0)
    else $error("drop beat malformed");

  // Reply beats carry one to eight bytes, and only the final one is partial.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !dropped |-> out_count != 4'd0 && out_count <= 4'd8 &&
                              (out_last || out_count == 4'd8))
    else $error("reply beat byte count out of range");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind catch_all_dns_responder dnsr_checker u_dnsr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .out_count (out_count),
  .out_last  (out_last),
  .dropped   (dropped)
);
